[rtl/spd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slotted page directory package
// Sizes, widths, command and result codes, and the control and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int PAGE_BYTES   = 4096;
	localparam int HEADER_BYTES = 4;
	localparam int SLOT_BYTES   = 4;
	localparam int MAX_SLOTS    = 1024;

	localparam int CMD_W    = 3;
	localparam int IDX_W    = 10;
	localparam int LEN_W    = 16;
	localparam int OFF_W    = 13;
	localparam int FREE_W   = 12;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = IDX_W + 1;
	localparam int DIR_W    = OFF_W + 1;
	localparam int NEED_W   = LEN_W + 1;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] result_t;

	localparam cmd_t CMD_CLEAR  = 3'd0;
	localparam cmd_t CMD_INSERT = 3'd1;
	localparam cmd_t CMD_DELETE = 3'd2;
	localparam cmd_t CMD_UPDATE = 3'd3;
	localparam cmd_t CMD_LOOKUP = 3'd4;

	localparam result_t RES_OK       = 2'd0;
	localparam result_t RES_NO_SPACE = 2'd1;
	localparam result_t RES_RANGE    = 2'd2;
	localparam result_t RES_EMPTY    = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_hold;
	} dp_stat_t;

endpackage

[rtl/spd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slotted page directory controller
// Two-state sequencer: takes a transaction and starts the directory read,
// then executes once the result register is free to be loaded.
// ----------------------------------------------------------------------------
module spd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  spd_pkg::dp_stat_t  stat,
	output spd_pkg::ctrl_cmd_t ctrl
);
	import spd_pkg::*;

	state_t state_q;
	state_t state_nxt;

	assign in_ready     = (state_q == S_IDLE);
	assign ctrl.capture = in_valid && (state_q == S_IDLE);
	assign ctrl.execute = (state_q == S_EXEC) && !stat.out_hold;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!stat.out_hold) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[rtl/spd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slotted page directory datapath
// Holds the slot count, the free pointer, the offset and length memories
// and the result register, and evaluates each command.
// ----------------------------------------------------------------------------
module spd_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  spd_pkg::ctrl_cmd_t              ctrl,
	output spd_pkg::dp_stat_t               stat,
	input  logic [spd_pkg::CMD_W-1:0]       command,
	input  logic [spd_pkg::IDX_W-1:0]       slot_index,
	input  logic [spd_pkg::LEN_W-1:0]       length,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [spd_pkg::STATUS_W-1:0]    status,
	output logic [spd_pkg::IDX_W-1:0]       slot_out,
	output logic [spd_pkg::OFF_W-1:0]       record_offset,
	output logic [spd_pkg::LEN_W-1:0]       record_length,
	output logic [spd_pkg::FREE_W-1:0]      free_bytes
);
	import spd_pkg::*;

	cmd_t             cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [LEN_W-1:0] len_q;

	logic [OFF_W-1:0] off_mem [MAX_SLOTS];
	logic [LEN_W-1:0] len_mem [MAX_SLOTS];
	logic [OFF_W-1:0] rd_off_q;
	logic [LEN_W-1:0] rd_len_q;

	logic [CNT_W-1:0] total_q;
	logic [OFF_W-1:0] fp_q;
	logic             out_valid_q;

	result_t          res_status_q;
	logic [IDX_W-1:0] res_slot_q;
	logic [OFF_W-1:0] res_off_q;
	logic [LEN_W-1:0] res_len_q;
	logic [FREE_W-1:0] res_free_q;

	logic [DIR_W-1:0]  dir_end;
	logic [DIR_W-1:0]  gap_pre;
	logic [DIR_W-1:0]  dir_end_post;
	logic [DIR_W-1:0]  gap_post;
	logic [NEED_W-1:0] need;
	logic              full;
	logic              in_range;

	logic [CNT_W-1:0] total_nxt;
	logic [OFF_W-1:0] fp_nxt;
	result_t          status_nxt;
	logic [IDX_W-1:0] slot_nxt;
	logic [OFF_W-1:0] off_nxt;
	logic [LEN_W-1:0] rlen_nxt;
	logic             wr_off;
	logic             wr_len;
	logic [IDX_W-1:0] wr_addr;
	logic [LEN_W-1:0] wr_len_data;

	assign stat.out_hold = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q <= command;
			idx_q <= slot_index;
			len_q <= length;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_off) begin
			off_mem[wr_addr] <= fp_nxt;
		end
		if (ctrl.capture) begin
			rd_off_q <= off_mem[slot_index];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_len) begin
			len_mem[wr_addr] <= wr_len_data;
		end
		if (ctrl.capture) begin
			rd_len_q <= len_mem[slot_index];
		end
	end

	always_comb begin
		dir_end  = DIR_W'(HEADER_BYTES) + DIR_W'(total_q) * DIR_W'(SLOT_BYTES);
		gap_pre  = ({1'b0, fp_q} >= dir_end) ? ({1'b0, fp_q} - dir_end) : '0;
		need     = {1'b0, len_q} + NEED_W'(SLOT_BYTES);
		full     = (total_q >= CNT_W'(MAX_SLOTS));
		in_range = ({1'b0, idx_q} < total_q);

		total_nxt   = total_q;
		fp_nxt      = fp_q;
		status_nxt  = RES_OK;
		slot_nxt    = idx_q;
		off_nxt     = '0;
		rlen_nxt    = '0;
		wr_off      = 1'b0;
		wr_len      = 1'b0;
		wr_addr     = idx_q;
		wr_len_data = len_q;

		case (cmd_q)
			CMD_CLEAR: begin
				total_nxt = '0;
				fp_nxt    = OFF_W'(PAGE_BYTES);
			end
			CMD_INSERT: begin
				if (full || (need > NEED_W'(gap_pre))) begin
					status_nxt = RES_NO_SPACE;
				end else begin
					fp_nxt    = fp_q - len_q[OFF_W-1:0];
					total_nxt = total_q + CNT_W'(1);
					slot_nxt  = total_q[IDX_W-1:0];
					off_nxt   = fp_nxt;
					rlen_nxt  = len_q;
					wr_addr   = total_q[IDX_W-1:0];
					wr_off    = ctrl.execute;
					wr_len    = ctrl.execute;
				end
			end
			CMD_DELETE: begin
				if (!in_range) begin
					status_nxt = RES_RANGE;
				end else begin
					wr_len_data = '0;
					wr_len      = ctrl.execute;
				end
			end
			CMD_UPDATE: begin
				if (!in_range) begin
					status_nxt = RES_RANGE;
				end else begin
					wr_len = ctrl.execute;
				end
			end
			CMD_LOOKUP: begin
				if (!in_range) begin
					status_nxt = RES_RANGE;
				end else if (rd_len_q == '0) begin
					status_nxt = RES_EMPTY;
				end else begin
					off_nxt  = rd_off_q;
					rlen_nxt = rd_len_q;
				end
			end
			default: begin
			end
		endcase

		dir_end_post = DIR_W'(HEADER_BYTES) + DIR_W'(total_nxt) * DIR_W'(SLOT_BYTES);
		gap_post     = ({1'b0, fp_nxt} >= dir_end_post) ?
			({1'b0, fp_nxt} - dir_end_post) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			fp_q        <= OFF_W'(PAGE_BYTES);
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.execute) begin
				total_q     <= total_nxt;
				fp_q        <= fp_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.execute) begin
			res_status_q <= status_nxt;
			res_slot_q   <= slot_nxt;
			res_off_q    <= off_nxt;
			res_len_q    <= rlen_nxt;
			res_free_q   <= gap_post[FREE_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_status_q;
	assign slot_out      = res_slot_q;
	assign record_offset = res_off_q;
	assign record_length = res_len_q;
	assign free_bytes    = res_free_q;

endmodule

[rtl/slotted_page_directory.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slotted page directory
// Keeps the slot count, free pointer and per-slot offset and length of a
// slotted page, and executes clear, insert, delete, update and lookup.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | command, slot_index, length
//   out     | out_valid / out_ready| status, slot_out, record_offset,
//           |                      | record_length, free_bytes
//
// The directory memories are read in the accepting cycle and the command
// executes in the S_EXEC state, when the entry is written back and the
// result register is loaded.
// A new transaction is accepted while the previous result is still waiting;
// execution holds only if the result register has not yet been taken.
// Reset clears the slot count and sets the free pointer to the page end.
// ----------------------------------------------------------------------------
module slotted_page_directory (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [spd_pkg::CMD_W-1:0]       command,
	input  logic [spd_pkg::IDX_W-1:0]       slot_index,
	input  logic [spd_pkg::LEN_W-1:0]       length,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [spd_pkg::STATUS_W-1:0]    status,
	output logic [spd_pkg::IDX_W-1:0]       slot_out,
	output logic [spd_pkg::OFF_W-1:0]       record_offset,
	output logic [spd_pkg::LEN_W-1:0]       record_length,
	output logic [spd_pkg::FREE_W-1:0]      free_bytes
);
	import spd_pkg::*;

	ctrl_cmd_t ctrl;
	dp_stat_t  stat;

	spd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	spd_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.command       (command),
		.slot_index    (slot_index),
		.length        (length),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.slot_out      (slot_out),
		.record_offset (record_offset),
		.record_length (record_length),
		.free_bytes    (free_bytes)
	);

endmodule
